// ===== design/mops_pkg.sv =====
// mops_pkg: shared types and constants of the most-overdue poll scheduler
// no dependencies; imported by mops_scan and most_overdue_poll_scheduler
package mops_pkg;

  // request type codes
  localparam logic REQ_POLL = 1'b0;
  localparam logic REQ_DONE = 1'b1;

  // interval registers on the configuration port
  localparam int CONFIG_COUNT = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int INTERVAL_W   = 16;
  localparam int TIME_W       = 32;
  localparam int READING_W    = 24;

  // voltage window 8.0 .. 16.0 in Q.8
  localparam logic signed [READING_W-1:0] VOLT_LOW_Q8  = 24'sd2048;
  localparam logic signed [READING_W-1:0] VOLT_HIGH_Q8 = 24'sd4096;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST [CONFIG_COUNT] = '{
    16'd300, 16'd250, 16'd250, 16'd5000, 16'd5000, 16'd300, 16'd300
  };

  // reset interval of an entry, zero for entries without a register
  function automatic logic [INTERVAL_W-1:0] interval_rst(input int idx);
    logic [INTERVAL_W-1:0] val;
    val = '0;
    for (int k = 0; k < CONFIG_COUNT; k++) begin
      if (k == idx) begin
        val = INTERVAL_RST[k];
      end
    end
    return val;
  endfunction

  // sequencer commands to the scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

endpackage

// ===== design/mops_scan.sv =====
// mops_scan: shared elapsed-time subtract and compare unit, one entry per step
// depends on mops_pkg (scan_ctrl_t, widths)
module mops_scan import mops_pkg::*; #(
  parameter int IDX_W = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_ctrl_t            ctrl_i,
  input  logic [TIME_W-1:0]     now_i,
  input  logic [TIME_W-1:0]     last_i,
  input  logic [INTERVAL_W-1:0] interval_i,
  input  logic [IDX_W-1:0]      idx_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      sel_o
);

  logic [TIME_W-1:0] elapsed;
  logic              hit;
  logic [TIME_W-1:0] best_q;
  logic              found_q;
  logic [IDX_W-1:0]  sel_q;

  // wrapping elapsed time; must reach the interval and beat the best so far
  assign elapsed = now_i - last_i;
  assign hit     = (elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, interval_i}) &&
                   (elapsed > best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      found_q <= 1'b0;
      sel_q   <= '0;
    end else if (ctrl_i.clear) begin
      best_q  <= '0;
      found_q <= 1'b0;
      sel_q   <= '0;
    end else if (ctrl_i.step && hit) begin
      best_q  <= elapsed;
      found_q <= 1'b1;
      sel_q   <= idx_i;
    end
  end

  assign found_o = found_q;
  assign sel_o   = sel_q;

  // nothing found means the running best is still zero
  a_best_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> best_q == '0)
    else $error("scan best nonzero without a hit");

  // a clear empties the running best
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (!found_q && best_q == '0))
    else $error("scan not empty after a clear");

  // a hit records the stepped entry
  a_hit_records: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.step && hit && !ctrl_i.clear) |=> (found_q && sel_q == $past(idx_i)))
    else $error("scan hit not recorded");

endmodule

// ===== design/most_overdue_poll_scheduler.sv =====
// most_overdue_poll_scheduler: top level, sequencer, interval and timestamp storage
// depends on mops_pkg and mops_scan
// sequence: a poll is scanned over every entry before its result is delivered, a completion
// goes straight to the deliver step; one item at a time, the input stalls until it is delivered,
// and the scan walks one entry per cycle; an output stall holds the deliver step
// reset: intervals return to their defaults, timestamps clear to zero, output empties
module most_overdue_poll_scheduler import mops_pkg::*; #(
  parameter int ENTRY_COUNT   = 7,
  parameter int VOLTAGE_ENTRY = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [INTERVAL_W-1:0]       cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [TIME_W-1:0]           now_ms_i,
  input  logic [2:0]                  entry_index_i,
  input  logic                        success_i,
  input  logic signed [READING_W-1:0] reading_value_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        grant_valid_o,
  output logic [2:0]                  grant_index_o,
  output logic                        reading_accepted_o
);

  localparam int              IdxW       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx    = IdxW'(ENTRY_COUNT - 1);
  localparam logic [4:0]      EntryLimit = 5'(ENTRY_COUNT);
  localparam logic [3:0]      VoltIdx    = 4'(VOLTAGE_ENTRY);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  scan_ctrl_t      scan_ctrl;
  logic            in_fire;
  logic            load_out;

  // per-entry storage
  logic [INTERVAL_W-1:0] intv_q [ENTRY_COUNT];
  logic [TIME_W-1:0]     last_q [ENTRY_COUNT];

  // captured item
  logic                        req_q;
  logic [TIME_W-1:0]           now_q;
  logic [2:0]                  ent_q;
  logic                        succ_q;
  logic signed [READING_W-1:0] rdg_q;

  // output register
  logic       out_valid_q;
  logic       grant_valid_q;
  logic [2:0] grant_idx_q;
  logic       acc_q;

  logic            found;
  logic [IdxW-1:0] sel;
  logic [3:0]      sel_ext;
  logic            ent_ok;
  logic            volt_ok;
  logic            store_en;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // interval registers; entries past the register list keep interval zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        intv_q[i] <= interval_rst(i);
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if ((i < CONFIG_COUNT) && (cfg_idx_i == CFG_IDX_W'(i))) begin
          intv_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // completion bookkeeping
  assign ent_ok   = ({2'b00, ent_q} < EntryLimit);
  assign volt_ok  = ({1'b0, ent_q} != VoltIdx) ||
                    ((rdg_q >= VOLT_LOW_Q8) && (rdg_q <= VOLT_HIGH_Q8));
  assign store_en = load_out && (req_q == REQ_DONE) && ent_ok && succ_q;

  // last request timestamps, written by a successful completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        last_q[i] <= '0;
      end
    end else if (store_en) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if ({1'b0, ent_q} == 4'(i)) begin
          last_q[i] <= now_q;
        end
      end
    end
  end

  // item capture on transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q  <= req_type_i;
      now_q  <= now_ms_i;
      ent_q  <= entry_index_i;
      succ_q <= success_i;
      rdg_q  <= reading_value_i;
    end
  end

  // sequencer: idle -> scan over all entries (polls only) -> deliver result
  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    scan_ctrl.clear = 1'b0;
    scan_ctrl.step  = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cnt_d           = '0;
          scan_ctrl.clear = 1'b1;
          state_d         = (req_type_i == REQ_POLL) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        // wait until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // shared elapsed compare unit, fed one entry per cycle
  mops_scan #(
    .IDX_W (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .now_i      (now_q),
    .last_i     (last_q[cnt_q]),
    .interval_i (intv_q[cnt_q]),
    .idx_i      (cnt_q),
    .found_o    (found),
    .sel_o      (sel)
  );

  // grant index is reported in three bits
  assign sel_ext = 4'(sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      grant_valid_q <= (req_q == REQ_POLL) && found;
      grant_idx_q   <= ((req_q == REQ_POLL) && found) ? sel_ext[2:0] : 3'd0;
      acc_q         <= (req_q == REQ_DONE) && ent_ok && succ_q && volt_ok;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign grant_valid_o      = grant_valid_q;
  assign grant_index_o      = grant_idx_q;
  assign reading_accepted_o = acc_q;

  // a result only appears after the deliver step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result appeared outside the deliver step");

  // a transfer always closes the input until the item is finished
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input open right after a transfer");

  // grant and reading acceptance never both set
  a_grant_xor_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(grant_valid_o && reading_accepted_o))
    else $error("grant and reading acceptance both set");

  // no grant means index zero
  a_no_grant_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !grant_valid_o) |-> grant_index_o == 3'd0)
    else $error("nonzero grant index without a grant");

endmodule
